>>> sv/tcs_pkg.sv
// Shared types and register map of the tetrahedron containment and sampling unit.
`timescale 1ns / 1ps

package tcs_pkg;

   localparam int CSR_WIDTH       = 48;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int VERTEX_COUNT    = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_0    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_1    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_2    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_3    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHECK_ORDER = 3'd4;

   typedef struct packed {
      logic pos;
      logic neg;
   } sign_type;

endpackage

>>> sv/tcs_face_unit.sv
// Pipelined face test: sign of the probe dotted with the cross product of edge_a and edge_b.
`timescale 1ns / 1ps

module tcs_face_unit #(
   parameter int EDGE_WIDTH = 17
) (
   input  logic                          clock,
   input  logic [2:0][EDGE_WIDTH-1:0]    edge_a,
   input  logic [2:0][EDGE_WIDTH-1:0]    edge_b,
   input  logic [2:0][EDGE_WIDTH-1:0]    probe,
   output tcs_pkg::sign_type             sign_out
);
   import tcs_pkg::*;

   localparam int PW = 2 * EDGE_WIDTH;
   localparam int NW = PW + 1;
   localparam int DW = EDGE_WIDTH + NW;
   localparam int SW = DW + 2;

   logic signed [PW-1:0]           prod_in [6];
   logic signed [PW-1:0]           prod_ff [6];
   logic [2:0][EDGE_WIDTH-1:0]     probe_ff;
   logic signed [NW-1:0]           normal_in [3];
   logic signed [DW-1:0]           dprod_in [3];
   logic signed [DW-1:0]           dprod_ff [3];
   logic signed [SW-1:0]           sum_in;
   sign_type                       sign_in;
   sign_type                       sign_ff;

   always_comb begin
      prod_in[0] = $signed(edge_a[1]) * $signed(edge_b[2]);
      prod_in[1] = $signed(edge_a[2]) * $signed(edge_b[1]);
      prod_in[2] = $signed(edge_a[2]) * $signed(edge_b[0]);
      prod_in[3] = $signed(edge_a[0]) * $signed(edge_b[2]);
      prod_in[4] = $signed(edge_a[0]) * $signed(edge_b[1]);
      prod_in[5] = $signed(edge_a[1]) * $signed(edge_b[0]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         normal_in[k] = NW'(prod_ff[2*k]) - NW'(prod_ff[2*k+1]);
         dprod_in[k]  = $signed(probe_ff[k]) * normal_in[k];
      end
   end

   always_comb begin
      sum_in      = SW'(dprod_ff[0]) + SW'(dprod_ff[1]) + SW'(dprod_ff[2]);
      sign_in.neg = sum_in[SW-1];
      sign_in.pos = ~sum_in[SW-1] & (|sum_in);
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      probe_ff <= probe;
      dprod_ff <= dprod_in;
      sign_ff  <= sign_in;
   end

   assign sign_out = sign_ff;

endmodule

>>> sv/tetrahedron_contain_and_sample_unit.sv
// Top level of the tetrahedron containment and sampling unit.
`timescale 1ns / 1ps

// The unit holds one tetrahedron in five write-only registers: four packed vertices and an
// orientation check flag, written through csr_write, csr_index and csr_wdata.
// A request beat is taken at every clock edge where start is high and busy is low; busy
// stays low, so a new request can enter in every cycle and the unit sustains one item
// per cycle.
// Mode 0 tests the point on req_point_* and returns rsp_inside_res; mode 1 folds the
// three fractions into the corner tetrahedron and returns the sampled point on
// rsp_sample_*.
// The result beat is marked by rsp_valid for one cycle. It passes through the input
// register, the edge stage, the cross product, dot product and sum stages of the face
// tests, and the output register, with the sampling multipliers running beside them.
// The receiver cannot stall; results leave the pipeline in request order, one per cycle.
// Reset clears the configuration registers and empties the pipeline.
// Registers may be written only when no request is in flight.
module tetrahedron_contain_and_sample_unit #(
   parameter int COORD_WIDTH    = 16,
   parameter int FRACTION_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_mode,
   input  logic signed [COORD_WIDTH-1:0]         req_point_x,
   input  logic signed [COORD_WIDTH-1:0]         req_point_y,
   input  logic signed [COORD_WIDTH-1:0]         req_point_z,
   input  logic [FRACTION_WIDTH-1:0]             req_rand_s,
   input  logic [FRACTION_WIDTH-1:0]             req_rand_t,
   input  logic [FRACTION_WIDTH-1:0]             req_rand_u,
   input  logic                                  csr_write,
   input  logic [tcs_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tcs_pkg::CSR_WIDTH-1:0]         csr_wdata,
   output logic                                  rsp_valid,
   output logic                                  rsp_inside_res,
   output logic signed [COORD_WIDTH-1:0]         rsp_sample_x,
   output logic signed [COORD_WIDTH-1:0]         rsp_sample_y,
   output logic signed [COORD_WIDTH-1:0]         rsp_sample_z
);
   import tcs_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int FW     = FRACTION_WIDTH;
   localparam int EW     = CW + 1;
   localparam int FOLD_W = FW + 3;
   localparam int MW     = FW + 2 + EW;
   localparam int FLW    = EW + 2;
   localparam int ACC    = CW + 5;
   localparam int VW     = (3 * CW > CSR_WIDTH) ? 3 * CW : CSR_WIDTH;
   localparam logic [FOLD_W-1:0] ONE = FOLD_W'(1) << FW;

   // Configuration registers.
   logic [CSR_WIDTH-1:0]          vertex_ff [VERTEX_COUNT];
   logic                          check_order_ff;
   logic [VW-1:0]                 vertex_ext [VERTEX_COUNT];
   logic signed [CW-1:0]          vtx [VERTEX_COUNT][3];

   // Input stage.
   logic                          accept;
   logic                          valid_0_ff;
   logic                          mode_0_ff;
   logic signed [CW-1:0]          point_0_ff [3];
   logic [FW-1:0]                 rand_0_ff [3];

   // Edge and fold stage.
   logic [2:0][EW-1:0]            edge_in [5];
   logic [2:0][EW-1:0]            edge_ff [5];
   logic [2:0][EW-1:0]            d0_in;
   logic [2:0][EW-1:0]            d1_in;
   logic [2:0][EW-1:0]            d0_ff;
   logic [2:0][EW-1:0]            d1_ff;
   logic [FOLD_W-1:0]             s0, t0, u0, s1, t1, s2, t2, u2;
   logic [FW:0]                   frac_in [3];
   logic [FW:0]                   frac_ff [3];
   logic                          valid_a_ff;
   logic                          mode_a_ff;

   // Sampling product stage.
   logic signed [FW+1:0]          frac_s [3];
   logic signed [MW-1:0]          prod_b_in [5][3];
   logic signed [MW-1:0]          prod_b_ff [5][3];
   logic                          valid_b_ff;
   logic                          mode_b_ff;

   // Sampling sum stages.
   logic signed [FLW-1:0]         floor_c [5][3];
   logic signed [ACC-1:0]         sum_c_in [2][3];
   logic signed [ACC-1:0]         sum_c_ff [2][3];
   logic signed [ACC-1:0]         sum_d_ff [2][3];
   logic                          valid_c_ff;
   logic                          mode_c_ff;
   logic                          valid_d_ff;
   logic                          mode_d_ff;

   // Face tests.
   sign_type                      face_sign [4];
   sign_type                      orient_sign;

   // Output stage.
   logic                          swap;
   logic                          any_pos;
   logic                          any_neg;
   logic                          inside_in;
   logic signed [ACC-1:0]         pick [3];
   logic signed [CW-1:0]          sample_in [3];
   logic                          rsp_valid_ff;
   logic                          rsp_inside_ff;
   logic signed [CW-1:0]          sample_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < VERTEX_COUNT; k++) begin
            vertex_ff[k] <= '0;
         end
         check_order_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VERTEX_0:    vertex_ff[0]   <= csr_wdata;
            CSR_VERTEX_1:    vertex_ff[1]   <= csr_wdata;
            CSR_VERTEX_2:    vertex_ff[2]   <= csr_wdata;
            CSR_VERTEX_3:    vertex_ff[3]   <= csr_wdata;
            CSR_CHECK_ORDER: check_order_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < VERTEX_COUNT; k++) begin
         vertex_ext[k] = VW'(vertex_ff[k]);
         for (int j = 0; j < 3; j++) begin
            vtx[k][j] = $signed(vertex_ext[k][j*CW +: CW]);
         end
      end
   end

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_0_ff <= 1'b0;
      end else begin
         valid_0_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      mode_0_ff     <= req_mode;
      point_0_ff[0] <= req_point_x;
      point_0_ff[1] <= req_point_y;
      point_0_ff[2] <= req_point_z;
      rand_0_ff[0]  <= req_rand_s;
      rand_0_ff[1]  <= req_rand_t;
      rand_0_ff[2]  <= req_rand_u;
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         edge_in[0][j] = EW'(vtx[1][j]) - EW'(vtx[0][j]);
         edge_in[1][j] = EW'(vtx[2][j]) - EW'(vtx[0][j]);
         edge_in[2][j] = EW'(vtx[3][j]) - EW'(vtx[0][j]);
         edge_in[3][j] = EW'(vtx[2][j]) - EW'(vtx[1][j]);
         edge_in[4][j] = EW'(vtx[3][j]) - EW'(vtx[1][j]);
         d0_in[j]      = EW'(point_0_ff[j]) - EW'(vtx[0][j]);
         d1_in[j]      = EW'(point_0_ff[j]) - EW'(vtx[1][j]);
      end
   end

   // Cube-cutting fold of the three fractions into the corner tetrahedron.
   always_comb begin
      s0 = FOLD_W'(rand_0_ff[0]);
      t0 = FOLD_W'(rand_0_ff[1]);
      u0 = FOLD_W'(rand_0_ff[2]);
      if (s0 + t0 > ONE) begin
         s1 = ONE - s0;
         t1 = ONE - t0;
      end else begin
         s1 = s0;
         t1 = t0;
      end
      s2 = s1;
      t2 = t1;
      u2 = u0;
      if (s1 + t1 + u0 > ONE) begin
         if (t1 + u0 > ONE) begin
            t2 = ONE - u0;
            u2 = ONE - s1 - t1;
         end else begin
            s2 = ONE - t1 - u0;
            u2 = s1 + t1 + u0 - ONE;
         end
      end
      frac_in[0] = s2[FW:0];
      frac_in[1] = t2[FW:0];
      frac_in[2] = u2[FW:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_0_ff;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
         valid_d_ff <= valid_c_ff;
         rsp_valid_ff <= valid_d_ff;
      end
   end

   always_ff @(posedge clock) begin
      edge_ff   <= edge_in;
      d0_ff     <= d0_in;
      d1_ff     <= d1_in;
      frac_ff   <= frac_in;
      mode_a_ff <= mode_0_ff;
      mode_b_ff <= mode_a_ff;
      mode_c_ff <= mode_b_ff;
      mode_d_ff <= mode_c_ff;
   end

   // Face normals of the unswapped vertex order; a swap only negates and permutes them.
   tcs_face_unit #(.EDGE_WIDTH(EW)) u_face_0 (
      .clock    (clock),
      .edge_a   (edge_ff[0]),
      .edge_b   (edge_ff[1]),
      .probe    (d0_ff),
      .sign_out (face_sign[0])
   );

   tcs_face_unit #(.EDGE_WIDTH(EW)) u_face_1 (
      .clock    (clock),
      .edge_a   (edge_ff[1]),
      .edge_b   (edge_ff[2]),
      .probe    (d0_ff),
      .sign_out (face_sign[1])
   );

   tcs_face_unit #(.EDGE_WIDTH(EW)) u_face_2 (
      .clock    (clock),
      .edge_a   (edge_ff[2]),
      .edge_b   (edge_ff[0]),
      .probe    (d0_ff),
      .sign_out (face_sign[2])
   );

   tcs_face_unit #(.EDGE_WIDTH(EW)) u_face_3 (
      .clock    (clock),
      .edge_a   (edge_ff[4]),
      .edge_b   (edge_ff[3]),
      .probe    (d1_ff),
      .sign_out (face_sign[3])
   );

   tcs_face_unit #(.EDGE_WIDTH(EW)) u_orient (
      .clock    (clock),
      .edge_a   (edge_ff[0]),
      .edge_b   (edge_ff[1]),
      .probe    (edge_ff[2]),
      .sign_out (orient_sign)
   );

   // Products for both vertex orders; the order is chosen once the orientation is known.
   always_comb begin
      for (int q = 0; q < 3; q++) begin
         frac_s[q] = $signed({1'b0, frac_ff[q]});
      end
      for (int j = 0; j < 3; j++) begin
         prod_b_in[0][j] = frac_s[0] * $signed(edge_ff[0][j]);
         prod_b_in[1][j] = frac_s[1] * $signed(edge_ff[1][j]);
         prod_b_in[2][j] = frac_s[2] * $signed(edge_ff[2][j]);
         prod_b_in[3][j] = frac_s[1] * $signed(edge_ff[0][j]);
         prod_b_in[4][j] = frac_s[0] * $signed(edge_ff[1][j]);
      end
   end

   always_ff @(posedge clock) begin
      prod_b_ff <= prod_b_in;
   end

   always_comb begin
      for (int q = 0; q < 5; q++) begin
         for (int j = 0; j < 3; j++) begin
            floor_c[q][j] = FLW'(prod_b_ff[q][j] >>> FW);
         end
      end
      for (int j = 0; j < 3; j++) begin
         sum_c_in[0][j] = ACC'(vtx[0][j]) + ACC'(floor_c[0][j]) + ACC'(floor_c[1][j])
                        + ACC'(floor_c[2][j]);
         sum_c_in[1][j] = ACC'(vtx[0][j]) + ACC'(floor_c[3][j]) + ACC'(floor_c[4][j])
                        + ACC'(floor_c[2][j]);
      end
   end

   always_ff @(posedge clock) begin
      sum_c_ff <= sum_c_in;
      sum_d_ff <= sum_c_ff;
   end

   always_comb begin
      swap    = check_order_ff & ~orient_sign.neg;
      any_pos = face_sign[0].pos | face_sign[1].pos | face_sign[2].pos | face_sign[3].pos;
      any_neg = face_sign[0].neg | face_sign[1].neg | face_sign[2].neg | face_sign[3].neg;
      inside_in = ~mode_d_ff & (swap ? ~any_neg : ~any_pos);
      for (int j = 0; j < 3; j++) begin
         pick[j] = swap ? sum_d_ff[1][j] : sum_d_ff[0][j];
         if (!mode_d_ff) begin
            sample_in[j] = '0;
         end else if ((&pick[j][ACC-1:CW-1]) || ~(|pick[j][ACC-1:CW-1])) begin
            sample_in[j] = pick[j][CW-1:0];
         end else if (pick[j][ACC-1]) begin
            sample_in[j] = {1'b1, {(CW-1){1'b0}}};
         end else begin
            sample_in[j] = {1'b0, {(CW-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= inside_in;
      sample_ff     <= sample_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_sample_x   = sample_ff[0];
   assign rsp_sample_y   = sample_ff[1];
   assign rsp_sample_z   = sample_ff[2];

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the tetrahedron containment and sampling unit.
`timescale 1ns / 1ps

module tb;
   import tcs_pkg::*;

   localparam logic MODE_TEST   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;
   localparam longint FRAC_ONE  = 64'sd65536;
   localparam longint COORD_MIN = -64'sd32768;
   localparam longint COORD_MAX = 64'sd32767;
   localparam int RSP_LATENCY   = 6;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      longint x;
      longint y;
      longint z;
   } vec3_t;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
      logic [15:0]        fs;
      logic [15:0]        ft;
      logic [15:0]        fu;
   } query_t;

   typedef struct packed {
      logic               contained;
      logic signed [15:0] sx;
      logic signed [15:0] sy;
      logic signed [15:0] sz;
   } answer_t;

   typedef struct packed {
      bit                         is_csr;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_WIDTH-1:0]       data;
      query_t                     query;
      bit                         known;
      answer_t                    want;
   } step_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_mode = MODE_TEST;
   logic signed [15:0] req_point_x = '0;
   logic signed [15:0] req_point_y = '0;
   logic signed [15:0] req_point_z = '0;
   logic [15:0] req_rand_s = '0;
   logic [15:0] req_rand_t = '0;
   logic [15:0] req_rand_u = '0;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_VERTEX_0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_inside_res;
   logic signed [15:0] rsp_sample_x;
   logic signed [15:0] rsp_sample_y;
   logic signed [15:0] rsp_sample_z;

   logic [CSR_WIDTH-1:0] shadow_vertex [4] = '{default: '0};
   bit shadow_check = 1'b0;
   answer_t next_answer = '0;
   answer_t answers_due [$];
   int error_count = 0;
   int cycle_count = 0;

   tetrahedron_contain_and_sample_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_point_z    (req_point_z),
      .req_rand_s     (req_rand_s),
      .req_rand_t     (req_rand_t),
      .req_rand_u     (req_rand_u),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_inside_res (rsp_inside_res),
      .rsp_sample_x   (rsp_sample_x),
      .rsp_sample_y   (rsp_sample_y),
      .rsp_sample_z   (rsp_sample_z)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic vec3_t vertex_of(logic [CSR_WIDTH-1:0] r);
      vec3_t v;
      v.x = longint'($signed(r[15:0]));
      v.y = longint'($signed(r[31:16]));
      v.z = longint'($signed(r[47:32]));
      return v;
   endfunction

   function automatic vec3_t vdiff(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = a.x - b.x;
      r.y = a.y - b.y;
      r.z = a.z - b.z;
      return r;
   endfunction

   function automatic vec3_t cross3(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
   endfunction

   function automatic longint dot3(vec3_t a, vec3_t b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   // Products are floored by the arithmetic shift, then the sum is clamped.
   function automatic logic [15:0] sample_axis(longint base, longint ea, longint eb,
                                               longint ec, longint s, longint t, longint u);
      longint c;
      c = base + ((s * ea) >>> 16) + ((t * eb) >>> 16) + ((u * ec) >>> 16);
      if (c < COORD_MIN) c = COORD_MIN;
      if (c > COORD_MAX) c = COORD_MAX;
      return c[15:0];
   endfunction

   function automatic answer_t predict_answer(query_t q);
      vec3_t v0, v1, v2, v3, held, e0, e1, e2, e3, e4, p;
      longint s, t, u, nt, nu;
      answer_t a;
      v0 = vertex_of(shadow_vertex[0]);
      v1 = vertex_of(shadow_vertex[1]);
      v2 = vertex_of(shadow_vertex[2]);
      v3 = vertex_of(shadow_vertex[3]);
      if (shadow_check && dot3(vdiff(v3, v0), cross3(vdiff(v1, v0), vdiff(v2, v0))) >= 0) begin
         held = v1;
         v1 = v2;
         v2 = held;
      end
      e0 = vdiff(v1, v0);
      e1 = vdiff(v2, v0);
      e2 = vdiff(v3, v0);
      a = '0;
      if (q.mode == MODE_TEST) begin
         p.x = longint'($signed(q.px));
         p.y = longint'($signed(q.py));
         p.z = longint'($signed(q.pz));
         e3 = vdiff(v2, v1);
         e4 = vdiff(v3, v1);
         a.contained = dot3(vdiff(p, v0), cross3(e0, e1)) <= 0
                    && dot3(vdiff(p, v0), cross3(e1, e2)) <= 0
                    && dot3(vdiff(p, v0), cross3(e2, e0)) <= 0
                    && dot3(vdiff(p, v1), cross3(e4, e3)) <= 0;
      end else begin
         s = longint'(q.fs);
         t = longint'(q.ft);
         u = longint'(q.fu);
         if (s + t > FRAC_ONE) begin
            s = FRAC_ONE - s;
            t = FRAC_ONE - t;
         end
         if (s + t + u > FRAC_ONE) begin
            if (t + u > FRAC_ONE) begin
               nt = FRAC_ONE - u;
               nu = FRAC_ONE - s - t;
               t = nt;
               u = nu;
            end else begin
               nt = FRAC_ONE - t - u;
               nu = s + t + u - FRAC_ONE;
               s = nt;
               u = nu;
            end
         end
         a.sx = sample_axis(v0.x, e0.x, e1.x, e2.x, s, t, u);
         a.sy = sample_axis(v0.y, e0.y, e1.y, e2.y, s, t, u);
         a.sz = sample_axis(v0.z, e0.z, e1.z, e2.z, s, t, u);
      end
      return a;
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endfunction

   function automatic logic [CSR_WIDTH-1:0] pack_vertex(int x, int y, int z);
      return {z[15:0], y[15:0], x[15:0]};
   endfunction

   function automatic query_t cmd(logic mode, int px, int py, int pz, int s, int t, int u);
      query_t q;
      q.mode = mode;
      q.px = px[15:0];
      q.py = py[15:0];
      q.pz = pz[15:0];
      q.fs = s[15:0];
      q.ft = t[15:0];
      q.fu = u[15:0];
      return q;
   endfunction

   function automatic step_t item_row(query_t q);
      step_t r;
      r = '0;
      r.query = q;
      return r;
   endfunction

   function automatic step_t known_row(query_t q, logic contained, int sx, int sy, int sz);
      step_t r;
      r = item_row(q);
      r.known = 1'b1;
      r.want.contained = contained;
      r.want.sx = sx[15:0];
      r.want.sy = sy[15:0];
      r.want.sz = sz[15:0];
      return r;
   endfunction

   function automatic step_t csr_row(logic [CSR_INDEX_WIDTH-1:0] index,
                                     logic [CSR_WIDTH-1:0] data);
      step_t r;
      r = '0;
      r.is_csr = 1'b1;
      r.index = index;
      r.data = data;
      return r;
   endfunction

   function automatic logic [15:0] edge_fraction();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd32768;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int edge_coord();
      case ($urandom_range(0, 2))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic query_t random_query();
      query_t q;
      vec3_t vx [4];
      vec3_t lo, hi, pick;
      int k;
      q.mode = $urandom_range(0, 1) ? MODE_SAMPLE : MODE_TEST;
      q.px = 16'($urandom);
      q.py = 16'($urandom);
      q.pz = 16'($urandom);
      q.fs = 16'($urandom);
      q.ft = 16'($urandom);
      q.fu = 16'($urandom);
      for (k = 0; k < 4; k++) vx[k] = vertex_of(shadow_vertex[k]);
      if (q.mode == MODE_SAMPLE) begin
         if ($urandom_range(0, 5) == 0) begin
            q.fs = edge_fraction();
            q.ft = edge_fraction();
            q.fu = edge_fraction();
         end
      end else begin
         lo = vx[0];
         hi = vx[0];
         for (k = 1; k < 4; k++) begin
            if (vx[k].x < lo.x) lo.x = vx[k].x;
            if (vx[k].y < lo.y) lo.y = vx[k].y;
            if (vx[k].z < lo.z) lo.z = vx[k].z;
            if (vx[k].x > hi.x) hi.x = vx[k].x;
            if (vx[k].y > hi.y) hi.y = vx[k].y;
            if (vx[k].z > hi.z) hi.z = vx[k].z;
         end
         case ($urandom_range(0, 3))
            1, 2: begin
               q.px = 16'(lo.x + longint'($urandom_range(0, int'(hi.x - lo.x))));
               q.py = 16'(lo.y + longint'($urandom_range(0, int'(hi.y - lo.y))));
               q.pz = 16'(lo.z + longint'($urandom_range(0, int'(hi.z - lo.z))));
            end
            3: begin
               pick = vx[$urandom_range(0, 3)];
               q.px = 16'(pick.x + longint'($urandom_range(0, 2)) - 1);
               q.py = 16'(pick.y + longint'($urandom_range(0, 2)) - 1);
               q.pz = 16'(pick.z + longint'($urandom_range(0, 2)) - 1);
            end
            default: ;
         endcase
      end
      return q;
   endfunction

   task automatic send(query_t q, bit known, answer_t want);
      @(negedge clock);
      start <= 1'b1;
      req_mode <= q.mode;
      req_point_x <= q.px;
      req_point_y <= q.py;
      req_point_z <= q.pz;
      req_rand_s <= q.fs;
      req_rand_t <= q.ft;
      req_rand_u <= q.fu;
      next_answer <= known ? want : predict_answer(q);
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (RSP_LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_WIDTH-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      case (index)
         CSR_VERTEX_0:    shadow_vertex[0] = data;
         CSR_VERTEX_1:    shadow_vertex[1] = data;
         CSR_VERTEX_2:    shadow_vertex[2] = data;
         CSR_VERTEX_3:    shadow_vertex[3] = data;
         CSR_CHECK_ORDER: shadow_check = data[0];
         default: ;
      endcase
   endtask

   task automatic configure_random();
      logic [CSR_WIDTH-1:0] verts [4];
      logic [63:0] raw;
      int style, cx, cy, cz, k;
      style = $urandom_range(0, 4);
      cx = int'($urandom_range(0, 60000)) - 30000;
      cy = int'($urandom_range(0, 60000)) - 30000;
      cz = int'($urandom_range(0, 60000)) - 30000;
      for (k = 0; k < 4; k++) begin
         raw = {$urandom, $urandom};
         case (style)
            0: verts[k] = raw[47:0];
            1: verts[k] = pack_vertex(cx + int'($urandom_range(0, 400)) - 200,
                                      cy + int'($urandom_range(0, 400)) - 200,
                                      cz + int'($urandom_range(0, 400)) - 200);
            2: verts[k] = pack_vertex(edge_coord(), edge_coord(), edge_coord());
            3: verts[k] = (k == 0 || $urandom_range(0, 1)) ? pack_vertex(cx, cy, cz)
                                                           : raw[47:0];
            default: verts[k] = pack_vertex(int'($urandom_range(0, 4000)) - 2000,
                                            int'($urandom_range(0, 4000)) - 2000,
                                            int'($urandom_range(0, 4000)) - 2000);
         endcase
      end
      write_csr(CSR_VERTEX_0, verts[0]);
      write_csr(CSR_VERTEX_1, verts[1]);
      write_csr(CSR_VERTEX_2, verts[2]);
      write_csr(CSR_VERTEX_3, verts[3]);
      raw = {$urandom, $urandom};
      write_csr(CSR_CHECK_ORDER, raw[47:0]);
      if ($urandom_range(0, 7) == 0) write_csr(CSR_UNMAPPED, raw[47:0] ^ {CSR_WIDTH{1'b1}});
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : check_rsp
      answer_t want;
      if (!reset) begin
         if (start && !busy) answers_due.push_back(next_answer);
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               flag_error($sformatf("result beat with nothing outstanding: inside=%0d x=%0d y=%0d z=%0d",
                          rsp_inside_res, rsp_sample_x, rsp_sample_y, rsp_sample_z));
            end else begin
               want = answers_due.pop_front();
               if (rsp_inside_res !== want.contained || rsp_sample_x !== want.sx
                   || rsp_sample_y !== want.sy || rsp_sample_z !== want.sz)
                  flag_error($sformatf({"mismatch: expected inside=%0d x=%0d y=%0d z=%0d,",
                                        " got inside=%0d x=%0d y=%0d z=%0d"},
                             want.contained, $signed(want.sx), $signed(want.sy),
                             $signed(want.sz), rsp_inside_res, rsp_sample_x,
                             rsp_sample_y, rsp_sample_z));
            end
         end
      end
   end

   initial begin
      step_t plan [$];
      int sent, count, k;
      bit burst;
      query_t q;

      // After reset every vertex sits at the origin, so every point is inside and
      // every sample collapses to the origin.
      plan.push_back(known_row(cmd(MODE_TEST, 0, 0, 0, 0, 0, 0), 1'b1, 0, 0, 0));
      plan.push_back(known_row(cmd(MODE_TEST, 32767, 32767, 32767, 0, 0, 0), 1'b1, 0, 0, 0));
      plan.push_back(known_row(cmd(MODE_TEST, -32768, -32768, -32768, 65535, 65535, 65535),
                               1'b1, 0, 0, 0));
      plan.push_back(known_row(cmd(MODE_TEST, 32767, -32768, 0, 0, 0, 0), 1'b1, 0, 0, 0));
      plan.push_back(known_row(cmd(MODE_SAMPLE, 0, 0, 0, 0, 0, 0), 1'b0, 0, 0, 0));
      plan.push_back(known_row(cmd(MODE_SAMPLE, -1, -1, -1, 65535, 65535, 65535), 1'b0, 0, 0, 0));
      plan.push_back(csr_row(CSR_VERTEX_0, pack_vertex(0, 0, 0)));
      plan.push_back(csr_row(CSR_VERTEX_1, pack_vertex(4000, 0, 0)));
      plan.push_back(csr_row(CSR_VERTEX_2, pack_vertex(0, 4000, 0)));
      plan.push_back(csr_row(CSR_VERTEX_3, pack_vertex(0, 0, 4000)));
      plan.push_back(csr_row(CSR_CHECK_ORDER, 48'hFFFF_FFFF_FFFF));
      plan.push_back(item_row(cmd(MODE_TEST, 1000, 1000, 1000, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_TEST, 4000, 0, 0, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_TEST, 2000, 2000, 0, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_TEST, 3000, 3000, 3000, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_TEST, -1, 0, 0, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_SAMPLE, 0, 0, 0, 65535, 65535, 65535)));
      plan.push_back(item_row(cmd(MODE_SAMPLE, 0, 0, 0, 30000, 20000, 30000)));
      plan.push_back(item_row(cmd(MODE_SAMPLE, 0, 0, 0, 10000, 40000, 40000)));
      plan.push_back(csr_row(CSR_CHECK_ORDER, 48'h0));
      plan.push_back(item_row(cmd(MODE_TEST, 1000, 1000, 1000, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_SAMPLE, 0, 0, 0, 20000, 10000, 5000)));
      // Flooring pushes the x coordinate below the signed range here.
      plan.push_back(csr_row(CSR_VERTEX_0, pack_vertex(-32767, 32767, 0)));
      plan.push_back(csr_row(CSR_VERTEX_1, pack_vertex(-32768, -32768, 32767)));
      plan.push_back(csr_row(CSR_VERTEX_2, pack_vertex(-32768, 32767, -32768)));
      plan.push_back(csr_row(CSR_VERTEX_3, pack_vertex(-32768, -32768, -32768)));
      plan.push_back(item_row(cmd(MODE_SAMPLE, 0, 0, 0, 1, 1, 1)));
      plan.push_back(item_row(cmd(MODE_TEST, -32768, -32768, -32768, 0, 0, 0)));
      plan.push_back(item_row(cmd(MODE_TEST, 32767, 32767, 32767, 0, 0, 0)));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain();
            write_csr(plan[i].index, plan[i].data);
         end else begin
            send(plan[i].query, plan[i].known, plan[i].want);
            pause($urandom_range(0, 3));
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         drain();
         configure_random();
         count = $urandom_range(40, 200);
         burst = ($urandom_range(0, 3) == 0);
         for (k = 0; k < count; k++) begin
            q = random_query();
            send(q, 1'b0, '0);
            sent++;
            if ($urandom_range(0, 63) == 0) drain();
            else pause(burst ? 0 : $urandom_range(0, 15));
         end
      end

      drain();
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
